// File: design/brp_pkg.sv
// ----------------------------------------------------------------------------
// brp_pkg: shared types and helpers for the byte-range parser
// Phase codes, result codes, word structs and the decimal accumulate step.
// ----------------------------------------------------------------------------
package brp_pkg;

   localparam int VALUE_WIDTH = 48;   // accumulator width, saturates at all ones
   localparam int OUT_WIDTH   = 48;   // width of the range fields on the port

   typedef enum logic [3:0] {
      PH_PREFIX0    = 4'd0,
      PH_PREFIX1    = 4'd1,
      PH_PREFIX2    = 4'd2,
      PH_PREFIX3    = 4'd3,
      PH_PREFIX4    = 4'd4,
      PH_PREFIX5    = 4'd5,
      PH_START      = 4'd6,
      PH_TESTTAIL   = 4'd7,
      PH_FIRST      = 4'd8,
      PH_TESTSECOND = 4'd9,
      PH_SECOND     = 4'd10,
      PH_ERROR      = 4'd11
   } phase_type;

   typedef enum logic [1:0] {
      OC_MORE  = 2'd0,
      OC_FINAL = 2'd1,
      OC_ERROR = 2'd2
   } outcome_type;

   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_EQUAL = 8'h3d;
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       end_of_value;
   } item_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] range_start;
      logic                 start_present;
      logic [OUT_WIDTH-1:0] range_stop;
      logic                 stop_present;
      outcome_type          outcome;
   } result_type;

   // expected character of "bytes=" at a prefix position
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h62;   // b
         3'd1:    ch = 8'h79;   // y
         3'd2:    ch = 8'h74;   // t
         3'd3:    ch = 8'h65;   // e
         3'd4:    ch = 8'h73;   // s
         default: ch = CH_EQUAL;
      endcase
      return ch;
   endfunction

   // acc*10 + d, clamped to all ones when it no longer fits
   function automatic logic [VALUE_WIDTH-1:0] add_digit(input logic [VALUE_WIDTH-1:0] acc,
                                                        input logic [3:0] d);
      logic [VALUE_WIDTH+3:0] wide;
      logic [VALUE_WIDTH-1:0] res;
      wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (VALUE_WIDTH+4)'(d);
      if (|wide[VALUE_WIDTH+3:VALUE_WIDTH]) begin
         res = '1;
      end else begin
         res = wide[VALUE_WIDTH-1:0];
      end
      return res;
   endfunction

   // port view of an accumulator: its low OUT_WIDTH bits
   function automatic logic [OUT_WIDTH-1:0] to_out(input logic [VALUE_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[OUT_WIDTH-1:0];
   endfunction

endpackage

// File: design/brp_in_stage.sv
// ----------------------------------------------------------------------------
// brp_in_stage: input word register
// Holds one accepted word until the parse stage consumes it.
// ----------------------------------------------------------------------------
module brp_in_stage
   import brp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_value_byte,
   input  logic       req_end_of_value,
   input  logic       advance,
   output logic       held_valid,
   output item_type   held_item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     take;

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.value_byte   <= req_value_byte;
         item_ff.end_of_value <= req_end_of_value;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// File: design/brp_parse.sv
// ----------------------------------------------------------------------------
// brp_parse: range header state machine
// Prefix match, number accumulation and range/error result generation.
// ----------------------------------------------------------------------------
module brp_parse
   import brp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output logic       res_valid,
   output result_type res
);

   phase_type              phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] start_ff, start_in;
   logic [VALUE_WIDTH-1:0] stop_ff, stop_in;
   logic                   given_ff, given_in;

   logic [7:0] ch;
   logic       is_digit;
   logic [3:0] digit;
   logic [7:0] folded;
   logic       prefix_ok;

   assign ch        = item.value_byte;
   assign is_digit  = ch inside {[CH_ZERO:CH_NINE]};
   assign digit     = ch[3:0];
   assign folded    = (prefix_char(phase_ff[2:0]) == CH_EQUAL) ? ch : (ch | CASE_BIT);
   assign prefix_ok = folded == prefix_char(phase_ff[2:0]);

   // next state
   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      stop_in  = stop_ff;
      given_in = given_ff;
      if (item.end_of_value) begin
         phase_in = PH_PREFIX0;
         start_in = '0;
         stop_in  = '0;
         given_in = 1'b0;
      end else begin
         case (phase_ff)
            PH_PREFIX0, PH_PREFIX1, PH_PREFIX2,
            PH_PREFIX3, PH_PREFIX4, PH_PREFIX5: begin
               phase_in = prefix_ok ? phase_type'(phase_ff + 4'd1) : PH_ERROR;
            end
            PH_START: begin
               start_in = '0;
               stop_in  = '0;
               if (ch == CH_DASH) begin
                  given_in = 1'b0;
                  phase_in = PH_TESTTAIL;
               end else if (is_digit) begin
                  given_in = 1'b1;
                  start_in = VALUE_WIDTH'(digit);
                  phase_in = PH_FIRST;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_TESTTAIL: begin
               if (is_digit) begin
                  stop_in  = VALUE_WIDTH'(digit);
                  phase_in = PH_SECOND;
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_FIRST: begin
               if (ch == CH_DASH) begin
                  phase_in = PH_TESTSECOND;
               end else if (is_digit) begin
                  start_in = add_digit(start_ff, digit);
               end else begin
                  phase_in = PH_ERROR;
               end
            end
            PH_TESTSECOND, PH_SECOND: begin
               if (ch == CH_COMMA) begin
                  phase_in = PH_START;
                  start_in = '0;
                  stop_in  = '0;
                  given_in = 1'b0;
               end else if (!is_digit) begin
                  phase_in = PH_ERROR;
               end else if (phase_ff == PH_TESTSECOND) begin
                  stop_in  = VALUE_WIDTH'(digit);
                  phase_in = PH_SECOND;
               end else begin
                  stop_in = add_digit(stop_ff, digit);
               end
            end
            default: begin
               phase_in = PH_ERROR;
            end
         endcase
      end
   end

   // result word
   always_comb begin
      logic in_range;
      in_range          = phase_ff inside {PH_TESTSECOND, PH_SECOND};
      res_valid         = 1'b0;
      res.start_present = given_ff;
      res.range_start   = given_ff ? to_out(start_ff) : '0;
      res.stop_present  = phase_ff == PH_SECOND;
      res.range_stop    = (phase_ff == PH_SECOND) ? to_out(stop_ff) : '0;
      res.outcome       = OC_MORE;
      if (item.end_of_value) begin
         if (in_range) begin
            res_valid   = 1'b1;
            res.outcome = OC_FINAL;
         end else if (phase_ff != PH_ERROR) begin
            res_valid = 1'b1;
            res       = '{default: '0, outcome: OC_ERROR};
         end
      end else if (in_range && ch == CH_COMMA) begin
         res_valid = 1'b1;
      end else if (phase_ff != PH_ERROR && phase_in == PH_ERROR) begin
         res_valid = 1'b1;
         res       = '{default: '0, outcome: OC_ERROR};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX0;
         start_ff <= '0;
         stop_ff  <= '0;
         given_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         stop_ff  <= stop_in;
         given_ff <= given_in;
      end
   end

endmodule

// File: design/http_byte_range_parser.sv
// ----------------------------------------------------------------------------
// http_byte_range_parser: streaming HTTP Range header value parser
// Matches "bytes=" (any case) and emits one word per a-b, a- or -b range.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one header byte per word; req_end_of_value=1 marks the end
//   of the value (its byte is ignored) and returns the parser to reset.
//   rsp_* carries one range word per closing comma or end marker, or a single
//   syntax-error word (all fields zero, outcome error). After an error, bytes
//   are dropped silently until the end marker, which then yields nothing.
//   Numbers saturate at 2^VALUE_WIDTH-1.
// Timing:
//   One word per cycle sustained while rsp_stall is low. A word is parsed
//   from the input register, and its result, if any, goes to the output
//   register. The single pass is a compare plus one x10 shift-add.
// Reset / stall:
//   Synchronous reset empties both registers and clears the parser state.
//   While rsp_stall holds a result, the parser keeps the input word waiting
//   and req_stall rises only once the input register is also occupied.
// ----------------------------------------------------------------------------
module http_byte_range_parser
   import brp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_value_byte,
   input  logic                 req_end_of_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [OUT_WIDTH-1:0] rsp_range_start,
   output logic                 rsp_start_present,
   output logic [OUT_WIDTH-1:0] rsp_range_stop,
   output logic                 rsp_stop_present,
   output logic [1:0]           rsp_outcome
);

   logic       held_valid;
   item_type   held_item;
   logic       advance;
   logic       res_valid;
   result_type res;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   // parse the held word when the output register can take its result
   assign advance = held_valid && (!out_valid_ff || !rsp_stall);

   brp_in_stage u_in (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value_byte   (req_value_byte),
      .req_end_of_value (req_end_of_value),
      .advance          (advance),
      .held_valid       (held_valid),
      .held_item        (held_item)
   );

   brp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (held_item),
      .res_valid (res_valid),
      .res       (res)
   );

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = res_valid;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_range_start   = out_ff.range_start;
   assign rsp_start_present = out_ff.start_present;
   assign rsp_range_stop    = out_ff.range_stop;
   assign rsp_stop_present  = out_ff.stop_present;
   assign rsp_outcome       = out_ff.outcome;

endmodule

// File: design/brp_checker.sv
// ----------------------------------------------------------------------------
// brp_checker: port-level checks for the range parser
// Result word consistency and output hold under stall.
// ----------------------------------------------------------------------------
module brp_checker
   import brp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [OUT_WIDTH-1:0] rsp_range_start,
   input logic                 rsp_start_present,
   input logic [OUT_WIDTH-1:0] rsp_range_stop,
   input logic                 rsp_stop_present,
   input logic [1:0]           rsp_outcome
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_range_start)
         && $stable(rsp_range_stop) && $stable(rsp_outcome))
      else $error("result word changed while stalled");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome == OC_ERROR |-> !rsp_start_present && !rsp_stop_present
         && rsp_range_start == '0 && rsp_range_stop == '0)
      else $error("error word carries range data");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_start_present || rsp_range_start == '0)
         && (rsp_stop_present || rsp_range_stop == '0))
      else $error("absent bound is not zero");

   a_range_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == OC_MORE || rsp_outcome == OC_FINAL)
         |-> rsp_start_present || rsp_stop_present)
      else $error("range word without any bound");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_outcome == OC_MORE || rsp_outcome == OC_FINAL
         || rsp_outcome == OC_ERROR)
      else $error("undefined outcome code");

endmodule

bind http_byte_range_parser brp_checker u_brp_checker (.*);
